// ===== design/slru_pkg.sv =====
// Shared types for the segmented LRU policy block.
// This file has no dependencies. The cell and top level modules use it.
package slru_pkg;

	localparam int unsigned CAPACITY_DEF = 128;
	localparam int unsigned KEY_BITS_DEF = 64;
	localparam int unsigned LIMIT_BITS   = 7;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd64;

	// Operation sent to all cells of the row at once
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PROMOTE,
		OP_DEMOTE,
		OP_EVICT,
		OP_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     old_prot;   // segment that the selected entry leaves (promote only)
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_PROMOTE,
		ST_DEMOTE,
		ST_EVICT,
		ST_INSERT,
		ST_DONE
	} seq_state_t;

endpackage

// ===== design/slru_cell.sv =====
// One cache entry of the segmented LRU store: its key, its segment flag and its rank.
// Depends on slru_pkg. The top level instantiates one cell per entry.
module slru_cell #(
	parameter int unsigned KB = slru_pkg::KEY_BITS_DEF,
	parameter int unsigned RW = 7,
	parameter int unsigned CW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slru_pkg::cell_cmd_t cmd,
	input  logic                sel,
	input  logic [RW-1:0]       old_rank,
	input  logic [KB-1:0]       bkey,
	input  logic [CW-1:0]       prob_cnt,
	input  logic [CW-1:0]       prot_cnt,
	output logic                match,
	output logic                lru_prob,
	output logic                lru_prot,
	output logic                free,
	output logic [KB-1:0]       key,
	output logic [RW-1:0]       rank,
	output logic                prot
);

	logic          valid_q;
	logic          prot_q;
	logic [RW-1:0] rank_q;
	logic [KB-1:0] key_q;
	logic          valid_d;
	logic          prot_d;
	logic [RW-1:0] rank_d;
	logic [RW-1:0] r_tmp;

	assign match    = valid_q && (key_q == bkey);
	assign free     = !valid_q;
	assign lru_prob = valid_q && !prot_q && (CW'(rank_q) == prob_cnt - CW'(1));
	assign lru_prot = valid_q && prot_q && (CW'(rank_q) == prot_cnt - CW'(1));
	assign key      = key_q;
	assign rank     = rank_q;
	assign prot     = prot_q;

	always_comb begin
		valid_d = valid_q;
		prot_d  = prot_q;
		rank_d  = rank_q;
		r_tmp   = rank_q;
		unique case (cmd.op)
			slru_pkg::OP_PROMOTE: begin
				if (sel) begin
					prot_d = 1'b1;
					rank_d = '0;
				end else if (valid_q) begin
					if (prot_q == cmd.old_prot && rank_q > old_rank)
						r_tmp = rank_q - RW'(1);
					if (prot_q)
						r_tmp = r_tmp + RW'(1);
					rank_d = r_tmp;
				end
			end
			slru_pkg::OP_DEMOTE, slru_pkg::OP_INSERT: begin
				if (sel) begin
					valid_d = 1'b1;
					prot_d  = 1'b0;
					rank_d  = '0;
				end else if (valid_q && !prot_q) begin
					rank_d = rank_q + RW'(1);
				end
			end
			slru_pkg::OP_EVICT: begin
				if (sel)
					valid_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			prot_q  <= 1'b0;
			rank_q  <= '0;
		end else begin
			valid_q <= valid_d;
			prot_q  <= prot_d;
			rank_q  <= rank_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == slru_pkg::OP_INSERT && sel)
			key_q <= bkey;
	end

endmodule

// ===== design/segmented_lru_cache_policy_top.sv =====
// Top level of the segmented LRU policy block: a sequencer over a row of entry cells.
// Depends on slru_pkg and slru_cell.
//
// A request carries a command (lookup or insert) and a key. A row of CAPACITY cells
// holds the entries. Each cell compares its key in parallel and adjusts its own
// recency rank when an operation goes out to the whole row. One operation reaches
// the row per cycle, and a request goes through a match step, then the steps it needs
// in this order (promote, demote, evict, insert), then loads the result register once
// the output register is free. A lookup miss needs no step, an insert miss takes evict
// and insert, a hit in protected only promote, and a hit in probation promote, demote
// and evict. The next request is taken while the last result still waits in the
// output register. segment_limit can be changed through cfg_we/cfg_wdata while no
// request is in progress. Values above CAPACITY/2 act as CAPACITY/2, and a value of
// zero acts like one. The store starts empty after reset and needs no clearing pass.
module segmented_lru_cache_policy_top #(
	parameter int unsigned CAPACITY = slru_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BITS = slru_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,     // segment_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,       // [63:0] key
	input  logic        s_tuser,       // [0] command: 1 insert, 0 lookup
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata        // [0] hit, [1] hit_was_protected, [2] evicted,
	                                   // [66:3] evicted_key, [71:67] zero
);

	localparam int unsigned RW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned LW   = (CW > slru_pkg::LIMIT_BITS) ? CW : slru_pkg::LIMIT_BITS;
	localparam int unsigned HALF = CAPACITY / 2;

	slru_pkg::seq_state_t state_q, state_d;
	slru_pkg::cell_cmd_t  cmd;

	logic [slru_pkg::LIMIT_BITS-1:0] limit_q;
	logic [CW-1:0]       prob_cnt_q, prot_cnt_q, lim;
	logic [KEY_BITS-1:0] key_q, ek_q, sel_key;
	logic                insert_q, hit_q, hwp_q, ev_q;
	logic [RW-1:0]       old_rank_q, sel_rank;
	logic                sel_prot;
	logic [CAPACITY-1:0] hit_sel_q, sel;
	logic [CAPACITY-1:0] match_v, lru_prob_v, lru_prot_v, free_v, free_pick;
	logic [CAPACITY-1:0][KEY_BITS-1:0] keys;
	logic [CAPACITY-1:0][RW-1:0]       ranks;
	logic [CAPACITY-1:0]               prots;
	logic                do_demote, do_evict, do_insert, out_free;

	// Effective limit: at most half the store
	always_comb begin
		if (LW'(limit_q) > LW'(HALF))
			lim = CW'(HALF);
		else
			lim = CW'(limit_q);
	end

	assign do_demote = prot_cnt_q >= lim;
	assign do_evict  = (prob_cnt_q >= lim) && (prob_cnt_q != '0);
	assign do_insert = |free_v;
	assign free_pick = free_v & (~free_v + CAPACITY'(1));
	assign out_free  = !m_tvalid || m_tready;
	assign s_tready  = (state_q == slru_pkg::ST_IDLE);

	// Selected cell's fields, one-hot OR
	always_comb begin
		sel_key  = '0;
		sel_rank = '0;
		sel_prot = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_key  = sel_key | (keys[i] & {KEY_BITS{sel[i]}});
			sel_rank = sel_rank | (ranks[i] & {RW{sel[i]}});
			sel_prot = sel_prot | (prots[i] & sel[i]);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slru_pkg::ST_IDLE:    if (s_tvalid) state_d = slru_pkg::ST_MATCH;
			slru_pkg::ST_MATCH: begin
				if (|match_v)
					state_d = slru_pkg::ST_PROMOTE;
				else if (insert_q)
					state_d = slru_pkg::ST_EVICT;
				else
					state_d = slru_pkg::ST_DONE;
			end
			slru_pkg::ST_PROMOTE: state_d = hwp_q ? slru_pkg::ST_DONE : slru_pkg::ST_DEMOTE;
			slru_pkg::ST_DEMOTE:  state_d = slru_pkg::ST_EVICT;
			slru_pkg::ST_EVICT:   state_d = hit_q ? slru_pkg::ST_DONE : slru_pkg::ST_INSERT;
			slru_pkg::ST_INSERT:  state_d = slru_pkg::ST_DONE;
			slru_pkg::ST_DONE:    if (out_free) state_d = slru_pkg::ST_IDLE;
			default:              state_d = slru_pkg::ST_IDLE;
		endcase
	end

	// Row command and cell select
	always_comb begin
		cmd.op       = slru_pkg::OP_NONE;
		cmd.old_prot = hwp_q;
		sel          = match_v;
		unique case (state_q)
			slru_pkg::ST_PROMOTE: begin
				cmd.op = slru_pkg::OP_PROMOTE;
				sel    = hit_sel_q;
			end
			slru_pkg::ST_DEMOTE: begin
				if (do_demote) cmd.op = slru_pkg::OP_DEMOTE;
				sel = lru_prot_v;
			end
			slru_pkg::ST_EVICT: begin
				if (do_evict) cmd.op = slru_pkg::OP_EVICT;
				sel = lru_prob_v;
			end
			slru_pkg::ST_INSERT: begin
				if (do_insert) cmd.op = slru_pkg::OP_INSERT;
				sel = free_pick;
			end
			default: ;
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		slru_cell #(.KB(KEY_BITS), .RW(RW), .CW(CW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.sel      (sel[g]),
			.old_rank (old_rank_q),
			.bkey     (key_q),
			.prob_cnt (prob_cnt_q),
			.prot_cnt (prot_cnt_q),
			.match    (match_v[g]),
			.lru_prob (lru_prob_v[g]),
			.lru_prot (lru_prot_v[g]),
			.free     (free_v[g]),
			.key      (keys[g]),
			.rank     (ranks[g]),
			.prot     (prots[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= slru_pkg::ST_IDLE;
			limit_q    <= slru_pkg::LIMIT_RESET;
			prob_cnt_q <= '0;
			prot_cnt_q <= '0;
			m_tvalid   <= 1'b0;
			hit_q      <= 1'b0;
			hwp_q      <= 1'b0;
			ev_q       <= 1'b0;
			insert_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				limit_q <= cfg_wdata;
			// a new result replaces the one leaving in the same cycle
			if (state_q == slru_pkg::ST_DONE && out_free)
				m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				slru_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						insert_q <= s_tuser;
						ev_q     <= 1'b0;
					end
				end
				slru_pkg::ST_MATCH: begin
					hit_q <= |match_v;
					hwp_q <= (|match_v) && sel_prot;
				end
				slru_pkg::ST_PROMOTE: begin
					prot_cnt_q <= prot_cnt_q + CW'(!hwp_q);
					prob_cnt_q <= prob_cnt_q - CW'(!hwp_q);
				end
				slru_pkg::ST_DEMOTE: begin
					if (do_demote) begin
						prot_cnt_q <= prot_cnt_q - CW'(1);
						prob_cnt_q <= prob_cnt_q + CW'(1);
					end
				end
				slru_pkg::ST_EVICT: begin
					if (do_evict) begin
						prob_cnt_q <= prob_cnt_q - CW'(1);
						ev_q       <= 1'b1;
					end
				end
				slru_pkg::ST_INSERT: begin
					if (do_insert)
						prob_cnt_q <= prob_cnt_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == slru_pkg::ST_IDLE && s_tvalid)
			key_q <= s_tdata[KEY_BITS-1:0];
		if (state_q == slru_pkg::ST_MATCH) begin
			hit_sel_q  <= match_v;
			old_rank_q <= sel_rank;
		end
		if (state_q == slru_pkg::ST_EVICT && do_evict)
			ek_q <= sel_key;
		if (state_q == slru_pkg::ST_DONE && out_free) begin
			m_tdata[0]     <= hit_q;
			m_tdata[1]     <= hwp_q;
			m_tdata[2]     <= ev_q;
			m_tdata[66:3]  <= ev_q ? 64'(ek_q) : 64'd0;
			m_tdata[71:67] <= '0;
		end
	end

	a_hwp_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || !m_tdata[1]))
		else $error("protected flag without hit");

	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slru_pkg::ST_MATCH) |-> $onehot0(match_v))
		else $error("key present in more than one entry");

	a_lru_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slru_pkg::ST_EVICT && do_evict) |-> $onehot(lru_prob_v))
		else $error("probation LRU not unique");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(prob_cnt_q) + 32'(prot_cnt_q)) <= CAPACITY)
		else $error("occupancy above capacity");

endmodule
